// File: rtl/scc_pkg.sv
package scc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic add_edge;
    logic clear;
    logic init;
    logic v_skip;
    logic start_v;
    logic k_init;
    logic k_take;
    logic step;
    logic fwd;
    logic load_out;
  } scc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic v_done;
    logic v_seen;
    logic k_zero;
    logic s_ok;
    logic depth_zero;
  } scc_sts_t;

endpackage

// File: rtl/scc_datapath.sv
module scc_datapath
  import scc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_data,
  input  logic [3:0]    src_vertex,
  input  logic [3:0]    dest_vertex,
  input  scc_cmd_t      cmd,
  output scc_sts_t      sts,
  output logic [4:0]    total
);

  logic [MAX_VERTICES-1:0] adj_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_r;
  logic [VW-1:0]           stack_r [MAX_VERTICES];
  logic [VW-1:0]           fin_r   [MAX_VERTICES];
  logic [CW-1:0]           depth_r;
  logic [CW-1:0]           fin_cnt_r;
  logic [CW-1:0]           comp_cnt_r;
  logic [CW-1:0]           v_r;
  logic [CW-1:0]           k_r;
  logic [4:0]              vcount_r;
  logic [4:0]              total_r;

  logic [CW-1:0]           n;
  logic [MAX_VERTICES-1:0] nmask;
  logic [VW-1:0]           top_idx;
  logic [VW-1:0]           u;
  logic [MAX_VERTICES-1:0] col;
  logic [MAX_VERTICES-1:0] cand;
  logic                    found;
  logic [VW-1:0]           pick;
  logic [VW-1:0]           s;
  logic [VW-1:0]           push_v;
  logic                    push;

  // vertices in use, clamped to the matrix size
  assign n = (vcount_r > 5'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_r);

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      nmask[j] = (CW'(j) < n);
      col[j]   = adj_r[j][u];
    end
  end

  assign top_idx = VW'(depth_r - CW'(1));
  assign u       = stack_r[top_idx];
  assign cand    = (cmd.fwd ? adj_r[u] : col) & ~visited_r & nmask;
  assign found   = |cand;

  // lowest unvisited neighbor
  always_comb begin
    pick = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (cand[j]) pick = VW'(j);
    end
  end

  assign s = fin_r[VW'(k_r - CW'(1))];

  assign sts.v_done     = (v_r >= n);
  assign sts.v_seen     = visited_r[VW'(v_r)];
  assign sts.k_zero     = (k_r == '0);
  assign sts.s_ok       = (CW'(s) < n) && !visited_r[s];
  assign sts.depth_zero = (depth_r == '0);

  assign push   = cmd.start_v || (cmd.k_take && sts.s_ok) || (cmd.step && found);
  assign push_v = cmd.start_v ? VW'(v_r) : (cmd.k_take ? s : pick);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r   <= 5'(MAX_VERTICES);
      visited_r  <= '0;
      depth_r    <= '0;
      fin_cnt_r  <= '0;
      comp_cnt_r <= '0;
      v_r        <= '0;
      k_r        <= '0;
    end else begin
      if (cfg_we) vcount_r <= cfg_data;
      if (cmd.init) begin
        visited_r  <= '0;
        depth_r    <= '0;
        fin_cnt_r  <= '0;
        comp_cnt_r <= '0;
        v_r        <= '0;
      end
      if (cmd.v_skip || cmd.start_v) v_r <= v_r + CW'(1);
      if (cmd.k_init) begin
        visited_r <= '0;
        k_r       <= fin_cnt_r;
      end
      if (cmd.k_take) begin
        k_r <= k_r - CW'(1);
        if (sts.s_ok) comp_cnt_r <= comp_cnt_r + CW'(1);
      end
      if (push) begin
        visited_r[push_v] <= 1'b1;
        depth_r           <= depth_r + CW'(1);
      end else if (cmd.step) begin
        depth_r <= depth_r - CW'(1);
        if (cmd.fwd) fin_cnt_r <= fin_cnt_r + CW'(1);
      end
    end
  end

  // adjacency matrix, cleared by reset and by the clear request
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < MAX_VERTICES; i++) adj_r[i] <= '0;
    end else if (cmd.add_edge) begin
      adj_r[src_vertex][dest_vertex] <= 1'b1;
    end
  end

  // scratch stores and result
  always_ff @(posedge clk) begin
    if (push) stack_r[VW'(depth_r)] <= push_v;
    if (cmd.step && !found && cmd.fwd) fin_r[VW'(fin_cnt_r)] <= u;
    if (cmd.load_out) total_r <= 5'(comp_cnt_r);
  end

  assign total = total_r;

endmodule

// File: rtl/scc_ctrl.sv
module scc_ctrl
  import scc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [1:0] in_opcode,
  output logic     out_valid,
  input  logic     out_ready,
  input  scc_sts_t sts,
  output scc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_FSEL, S_FWALK, S_TSEL, S_TWALK, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(in_opcode))
            OP_ADD:     cmd.add_edge = 1'b1;
            OP_CLEAR:   cmd.clear = 1'b1;
            OP_COMPUTE: begin
              cmd.init  = 1'b1;
              state_nxt = S_FSEL;
            end
            default: ;
          endcase
        end
      end
      S_FSEL: begin
        if (sts.v_done) begin
          cmd.k_init = 1'b1;
          state_nxt  = S_TSEL;
        end else if (sts.v_seen) begin
          cmd.v_skip = 1'b1;
        end else begin
          cmd.start_v = 1'b1;
          state_nxt   = S_FWALK;
        end
      end
      S_FWALK: begin
        cmd.fwd = 1'b1;
        if (sts.depth_zero) state_nxt = S_FSEL;
        else cmd.step = 1'b1;
      end
      S_TSEL: begin
        if (sts.k_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.k_take = 1'b1;
          if (sts.s_ok) state_nxt = S_TWALK;
        end
      end
      S_TWALK: begin
        if (sts.depth_zero) state_nxt = S_TSEL;
        else cmd.step = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/strongly_connected_component_count_top.sv
// Strongly connected component counter over a directed graph of up to
// 16 vertices, held as an adjacency bit matrix.
// Request channel (in_valid/in_ready): in_opcode selects add edge
// (src -> dest), compute, or clear all edges. Add and clear give no
// result; unused opcode 3 is dropped.
// Compute runs a forward depth-first pass recording finish order, then a
// pass over the transposed matrix in decreasing finish order, one stack
// push or pop per cycle. Each pass tries every vertex in use as a start
// and pushes and pops each once. in_ready stays low meanwhile.
// Result channel (out_valid/out_ready): one component_total per compute,
// held in an output register; the next request is taken while a result
// waits. A finished compute holds in its last state until that register
// frees; a stalled receiver stalls the next compute and later requests.
// Config (cfg_valid/cfg_ready, always ready): vertex_count, write only
// while idle. Reset (rst_n, synchronous, active low) empties the matrix,
// drops any pending result and sets vertex_count to 16.
module strongly_connected_component_count_top
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_vertex_count,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_src_vertex,
  input  logic [3:0] in_dest_vertex,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_component_total
);

  scc_cmd_t cmd;
  scc_sts_t sts;

  assign cfg_ready = 1'b1;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  scc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_vertex_count),
    .src_vertex  (in_src_vertex),
    .dest_vertex (in_dest_vertex),
    .cmd         (cmd),
    .sts         (sts),
    .total       (out_component_total)
  );

  // a compute request closes the request channel while it runs
  a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_COMPUTE |=> !in_ready)
    else $error("request taken during compute");

  // a component count never exceeds the vertex limit
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_component_total <= 5'(MAX_VERTICES))
    else $error("component count out of range");

  // a new result appears only as a compute finishes
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

endmodule
